@@ rtl/core/tccw_pkg.sv @@
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types, character codes and the Latin-1 to code page 437 map for the
// text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int SCREEN_COLUMNS_DEF = 80;
  localparam int SCREEN_LINES_DEF   = 50;

  // command codes
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_SET = 1'b1;

  // control glyphs after mapping
  localparam logic [7:0] GLYPH_NONE  = 8'h00;
  localparam logic [7:0] GLYPH_BS    = 8'h08;
  localparam logic [7:0] GLYPH_TAB   = 8'h09;
  localparam logic [7:0] GLYPH_LF    = 8'h0A;
  localparam logic [7:0] GLYPH_CR    = 8'h0D;
  localparam logic [7:0] GLYPH_SPACE = 8'h20;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [5:0] set_row;
    logic [6:0] set_col;
  } item_t;

  typedef struct packed {
    logic        write_valid;
    logic [11:0] cell_index;
    logic [15:0] cell_value;
    logic [6:0]  cursor_col_now;
    logic [5:0]  cursor_row_now;
    logic        off_screen;
  } result_t;

  function automatic logic [7:0] map_cp437(input logic [7:0] c);
    logic [7:0] g;
    case (c)
      8'hE4:   g = 8'h84;
      8'hF6:   g = 8'h94;
      8'hFC:   g = 8'h81;
      8'hDF:   g = 8'hE1;
      8'hA7:   g = 8'h15;
      8'hB0:   g = 8'hF8;
      8'hC4:   g = 8'h8E;
      8'hD6:   g = 8'h99;
      8'hDC:   g = 8'h9A;
      8'hB2:   g = 8'hFD;
      8'hB3:   g = 8'h00;
      8'h80:   g = 8'hEE;
      8'hB5:   g = 8'hE6;
      8'hB6:   g = 8'h14;
      8'hC6:   g = 8'h92;
      8'hE6:   g = 8'h91;
      8'hF1:   g = 8'hA4;
      8'hD1:   g = 8'hA5;
      8'hE7:   g = 8'h87;
      8'hC7:   g = 8'h80;
      8'hBF:   g = 8'hA8;
      8'hA1:   g = 8'hAD;
      8'hA2:   g = 8'h0B;
      8'hA3:   g = 8'h9C;
      8'hBD:   g = 8'hAB;
      8'hBC:   g = 8'hAC;
      8'hA5:   g = 8'h9D;
      8'hF7:   g = 8'hF6;
      8'hAC:   g = 8'hAA;
      8'hAB:   g = 8'hAE;
      8'hBB:   g = 8'hAF;
      default: g = c;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/core/tccw_step.sv @@
// ----------------------------------------------------------------------------
// tccw_step
// Cursor update and cell write for one transaction: maps the character,
// handles the control glyphs and forms the result and the next cursor.
// ----------------------------------------------------------------------------
module tccw_step #(
  parameter int SCREEN_COLUMNS = tccw_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_LINES   = tccw_pkg::SCREEN_LINES_DEF,
  parameter int COLW           = $clog2(SCREEN_COLUMNS),
  parameter int ROWW           = $clog2(SCREEN_LINES + 1)
) (
  input  tccw_pkg::item_t   item,
  input  logic [COLW-1:0]   cur_col,
  input  logic [ROWW-1:0]   cur_row,
  output logic [COLW-1:0]   nxt_col,
  output logic [ROWW-1:0]   nxt_row,
  output tccw_pkg::result_t res
);
  import tccw_pkg::*;

  // wide enough for a tab from the last column
  localparam int CW = $clog2(SCREEN_COLUMNS + 8);

  localparam logic [CW-1:0]   LAST_COL = CW'(SCREEN_COLUMNS - 1);
  localparam logic [CW-1:0]   NCOLS    = CW'(SCREEN_COLUMNS);
  localparam logic [ROWW-1:0] NLINES   = ROWW'(SCREEN_LINES);

  logic [7:0]      glyph;
  logic [7:0]      wglyph;
  logic [CW-1:0]   col_t;
  logic [CW-1:0]   col_tab;
  logic [CW-1:0]   wcol;
  logic [ROWW-1:0] row_t;
  logic [ROWW-1:0] wrow;
  logic            want;

  assign glyph   = map_cp437(item.char_code);
  assign col_tab = CW'(CW'(cur_col) + CW'(8)) & ~CW'(7);

  always_comb begin
    col_t  = CW'(cur_col);
    row_t  = cur_row;
    want   = 1'b0;
    wrow   = cur_row;
    wcol   = CW'(cur_col);
    wglyph = GLYPH_NONE;
    res    = '0;

    if (item.cmd == CMD_SET) begin
      row_t = (ROWW'(item.set_row) > NLINES || 32'(item.set_row) > SCREEN_LINES) ?
              NLINES : ROWW'(item.set_row);
      col_t = (32'(item.set_col) >= SCREEN_COLUMNS) ? LAST_COL : CW'(item.set_col);
    end else begin
      case (glyph)
        GLYPH_BS: begin
          if (cur_col != '0) begin
            col_t = CW'(cur_col) - CW'(1);
            want  = 1'b1;
          end else if (cur_row != '0) begin
            col_t = LAST_COL;
            row_t = cur_row - ROWW'(1);
            want  = 1'b1;
          end
          wrow   = row_t;
          wcol   = col_t;
          wglyph = GLYPH_SPACE;
        end
        GLYPH_TAB: col_t = col_tab;
        GLYPH_CR:  col_t = '0;
        GLYPH_LF: begin
          col_t = '0;
          if (row_t < NLINES) row_t = row_t + ROWW'(1);
        end
        default: begin
          if (glyph != GLYPH_NONE) begin
            want   = 1'b1;
            wglyph = glyph;
            col_t  = CW'(cur_col) + CW'(1);
          end
        end
      endcase

      // wrap at the column limit
      if (col_t >= NCOLS) begin
        col_t = '0;
        if (row_t < NLINES) row_t = row_t + ROWW'(1);
      end

      if (want) begin
        if (wrow >= NLINES) begin
          res.off_screen = 1'b1;
        end else begin
          res.write_valid = 1'b1;
          res.cell_index  = 12'(32'(wrow) * SCREEN_COLUMNS + 32'(wcol));
          res.cell_value  = {item.attribute, wglyph};
        end
      end
    end

    res.cursor_col_now = 7'(col_t);
    res.cursor_row_now = 6'(row_t);
  end

  assign nxt_col = COLW'(col_t);
  assign nxt_row = row_t;

endmodule

@@ rtl/core/text_console_char_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console character writer with a cursor.
// ----------------------------------------------------------------------------
// Each input transaction either puts one Latin-1 character at the cursor or
// sets the cursor. Every transaction yields exactly one result transaction:
// the screen cell to write (if any), the cursor after the item and an
// off-screen flag for writes suppressed below the last line.
//
// Both channels use valid/stall. An input transaction lands in an input
// register; from there the map, cursor update and cell address are
// evaluated and registered into the output register once it is free or
// being taken, and out_valid rises as it loads. Throughput is one
// transaction per cycle while the receiver does not stall. The cursor
// registers update in the same cycle the result register loads, so
// back-to-back characters see each other's cursor moves.
//
// When the receiver stalls, the result holds and one more transaction is
// taken into the input register; in_stall rises only once both are full.
// Reset clears both valid flags and puts the cursor at row 0, column 0.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
  parameter int SCREEN_COLUMNS = tccw_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_LINES   = tccw_pkg::SCREEN_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_attribute,
  input  logic [5:0]  in_set_row,
  input  logic [6:0]  in_set_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_valid,
  output logic [11:0] out_cell_index,
  output logic [15:0] out_cell_value,
  output logic [6:0]  out_cursor_col_now,
  output logic [5:0]  out_cursor_row_now,
  output logic        out_off_screen
);
  import tccw_pkg::*;

  localparam int COLW = $clog2(SCREEN_COLUMNS);
  localparam int ROWW = $clog2(SCREEN_LINES + 1);

  item_t           item_r;
  logic            in_v_r;
  logic            in_v_nxt;
  result_t         res_r;
  result_t         res_nxt;
  logic            out_v_r;
  logic            out_v_nxt;
  logic [COLW-1:0] col_r;
  logic [COLW-1:0] col_nxt;
  logic [ROWW-1:0] row_r;
  logic [ROWW-1:0] row_nxt;
  logic            advance;
  logic            accept;

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign in_v_nxt  = accept ? 1'b1 : (advance ? 1'b0 : in_v_r);
  assign out_v_nxt = advance ? 1'b1 : (out_v_r && out_stall);

  tccw_step #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_LINES  (SCREEN_LINES),
    .COLW          (COLW),
    .ROWW          (ROWW)
  ) u_step (
    .item    (item_r),
    .cur_col (col_r),
    .cur_row (row_r),
    .nxt_col (col_nxt),
    .nxt_row (row_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (advance) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{cmd: in_cmd, char_code: in_char_code, attribute: in_attribute,
                  set_row: in_set_row, set_col: in_set_col};
    end
    // hold the result while stalled
    if (advance) res_r <= res_nxt;
  end

  assign out_valid          = out_v_r;
  assign out_write_valid    = res_r.write_valid;
  assign out_cell_index     = res_r.cell_index;
  assign out_cell_value     = res_r.cell_value;
  assign out_cursor_col_now = res_r.cursor_col_now;
  assign out_cursor_row_now = res_r.cursor_row_now;
  assign out_off_screen     = res_r.off_screen;

endmodule

@@ rtl/core/tccw_checker.sv @@
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks for the text console character writer, bound to the top.
// ----------------------------------------------------------------------------
module tccw_checker #(
  parameter int SCREEN_COLUMNS = tccw_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_LINES   = tccw_pkg::SCREEN_LINES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_write_valid,
  input logic [11:0] out_cell_index,
  input logic [15:0] out_cell_value,
  input logic [6:0]  out_cursor_col_now,
  input logic [5:0]  out_cursor_row_now,
  input logic        out_off_screen
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_index) &&
    $stable(out_cell_value) && $stable(out_cursor_col_now) &&
    $stable(out_cursor_row_now) && $stable(out_write_valid))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_write_valid && out_off_screen))
    else $error("write and off-screen both set");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_cell_index == 12'd0 && out_cell_value == 16'd0)
    else $error("cell fields nonzero without a write");

  // cursor column stays on the grid, row at most one below the last line; skipped where the port width truncates
  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (SCREEN_COLUMNS > 128 || 32'(out_cursor_col_now) < SCREEN_COLUMNS) &&
                  (SCREEN_LINES > 63 || 32'(out_cursor_row_now) <= SCREEN_LINES))
    else $error("cursor outside the screen");

endmodule

bind text_console_char_writer tccw_checker #(
  .SCREEN_COLUMNS(SCREEN_COLUMNS),
  .SCREEN_LINES  (SCREEN_LINES)
) u_tccw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_write_valid   (out_write_valid),
  .out_cell_index    (out_cell_index),
  .out_cell_value    (out_cell_value),
  .out_cursor_col_now(out_cursor_col_now),
  .out_cursor_row_now(out_cursor_row_now),
  .out_off_screen    (out_off_screen)
);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_console_char_writer: puts, control characters
// and cursor sets are sent over the valid/stall input, every result
// transaction is compared field by field against a cursor and cell predictor,
// under random sender gaps, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import tccw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = CMD_PUT;
  logic [7:0]  in_char_code = 8'h00;
  logic [7:0]  in_attribute = 8'h00;
  logic [5:0]  in_set_row = 6'd0;
  logic [6:0]  in_set_col = 7'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_write_valid;
  logic [11:0] out_cell_index;
  logic [15:0] out_cell_value;
  logic [6:0]  out_cursor_col_now;
  logic [5:0]  out_cursor_row_now;
  logic        out_off_screen;

  text_console_char_writer #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_LINES  (ROWS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_char_code      (in_char_code),
    .in_attribute      (in_attribute),
    .in_set_row        (in_set_row),
    .in_set_col        (in_set_col),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_valid   (out_write_valid),
    .out_cell_index    (out_cell_index),
    .out_cell_value    (out_cell_value),
    .out_cursor_col_now(out_cursor_col_now),
    .out_cursor_row_now(out_cursor_row_now),
    .out_off_screen    (out_off_screen)
  );

  // predictor state
  int      cursor_col_q;
  int      cursor_row_q;
  result_t pending_cells[$];

  int n_errors;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_left;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] latin1_to_cp437(input logic [7:0] c);
    logic [7:0] g;
    g = c;
    case (c)
      8'hE4: g = 8'h84;
      8'hF6: g = 8'h94;
      8'hFC: g = 8'h81;
      8'hDF: g = 8'hE1;
      8'hA7: g = 8'h15;
      8'hB0: g = 8'hF8;
      8'hC4: g = 8'h8E;
      8'hD6: g = 8'h99;
      8'hDC: g = 8'h9A;
      8'hB2: g = 8'hFD;
      8'hB3: g = 8'h00;
      8'h80: g = 8'hEE;
      8'hB5: g = 8'hE6;
      8'hB6: g = 8'h14;
      8'hC6: g = 8'h92;
      8'hE6: g = 8'h91;
      8'hF1: g = 8'hA4;
      8'hD1: g = 8'hA5;
      8'hE7: g = 8'h87;
      8'hC7: g = 8'h80;
      8'hBF: g = 8'hA8;
      8'hA1: g = 8'hAD;
      8'hA2: g = 8'h0B;
      8'hA3: g = 8'h9C;
      8'hBD: g = 8'hAB;
      8'hBC: g = 8'hAC;
      8'hA5: g = 8'h9D;
      8'hF7: g = 8'hF6;
      8'hAC: g = 8'hAA;
      8'hAB: g = 8'hAE;
      8'hBB: g = 8'hAF;
      default: ;
    endcase
    return g;
  endfunction

  // Advance the cursor model by one item and return the cell write it causes.
  function automatic result_t console_step(input item_t it);
    result_t    r;
    logic [7:0] g;
    logic [7:0] glyph;
    int         col;
    int         row;
    int         wrow;
    int         wcol;
    bit         want;
    r     = '0;
    col   = cursor_col_q;
    row   = cursor_row_q;
    wrow  = 0;
    wcol  = 0;
    want  = 1'b0;
    glyph = GLYPH_NONE;
    if (it.cmd == CMD_SET) begin
      row = (it.set_row > ROWS) ? ROWS : it.set_row;
      col = (it.set_col >= COLS) ? COLS - 1 : it.set_col;
    end else begin
      g = latin1_to_cp437(it.char_code);
      case (g)
        GLYPH_BS: begin
          if (col > 0) begin
            col--;
            want = 1'b1;
          end else if (row > 0) begin
            col = COLS - 1;
            row--;
            want = 1'b1;
          end
          wrow  = row;
          wcol  = col;
          glyph = GLYPH_SPACE;
        end
        GLYPH_TAB: col = (col + 8) & ~7;
        GLYPH_CR:  col = 0;
        GLYPH_LF: begin
          col = 0;
          if (row < ROWS) row++;
        end
        GLYPH_NONE: ;
        default: begin
          want  = 1'b1;
          wrow  = row;
          wcol  = col;
          glyph = g;
          col++;
        end
      endcase
      if (col >= COLS) begin
        col = 0;
        if (row < ROWS) row++;
      end
      if (want) begin
        if (wrow >= ROWS) begin
          r.off_screen = 1'b1;
        end else begin
          r.write_valid = 1'b1;
          r.cell_index  = 12'(wrow * COLS + wcol);
          r.cell_value  = {it.attribute, glyph};
        end
      end
    end
    r.cursor_col_now = 7'(col);
    r.cursor_row_now = 6'(row);
    cursor_col_q = col;
    cursor_row_q = row;
    return r;
  endfunction

  function automatic item_t put_item(input logic [7:0] ch, input logic [7:0] attr);
    item_t it;
    it.cmd       = CMD_PUT;
    it.char_code = ch;
    it.attribute = attr;
    it.set_row   = 6'($urandom_range(63));
    it.set_col   = 7'($urandom_range(127));
    return it;
  endfunction

  function automatic item_t set_item(input logic [5:0] r, input logic [6:0] c);
    item_t it;
    it.cmd       = CMD_SET;
    it.char_code = 8'($urandom_range(255));
    it.attribute = 8'($urandom_range(255));
    it.set_row   = r;
    it.set_col   = c;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t      it;
    int         sel;
    logic [7:0] ctl[4];
    ctl = '{GLYPH_BS, GLYPH_TAB, GLYPH_CR, GLYPH_LF};
    sel = $urandom_range(99);
    it  = put_item(8'($urandom_range(255)), 8'($urandom_range(255)));
    if (sel < 9) begin
      if ($urandom_range(7) == 0) begin
        it = set_item(6'($urandom_range(63)), 7'($urandom_range(127)));
      end else begin
        it = set_item(6'($urandom_range(ROWS)), 7'($urandom_range(COLS - 1)));
      end
    end else if (sel < 22) begin
      it.char_code = ctl[$urandom_range(3)];
    end else if (sel < 26) begin
      it.char_code = ($urandom_range(1) != 0) ? 8'hB3 : 8'h00;
    end else if (sel < 60) begin
      it.char_code = 8'($urandom_range(8'h7E, 8'h20));
    end
    return it;
  endfunction

  // Offer one transaction and hold it until the block takes it.
  task automatic send_item(input item_t it);
    logic stalled;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= it.cmd;
    in_char_code <= it.char_code;
    in_attribute <= it.attribute;
    in_set_row   <= it.set_row;
    in_set_col   <= it.set_col;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    pending_cells.push_back(console_step(it));
  endtask

  // Drop valid and wait for every expected result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Result checker: sample before the edge at which the transaction is taken.
  initial begin
    result_t exp_r;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_cells.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual index %0h value %0h",
                   $realtime, out_cell_index, out_cell_value);
          n_errors++;
        end else begin
          exp_r = pending_cells.pop_front();
          check_field("write_valid", exp_r.write_valid, out_write_valid);
          check_field("cell_index", exp_r.cell_index, out_cell_index);
          check_field("cell_value", exp_r.cell_value, out_cell_value);
          check_field("cursor_col_now", exp_r.cursor_col_now, out_cursor_col_now);
          check_field("cursor_row_now", exp_r.cursor_row_now, out_cursor_row_now);
          check_field("off_screen", exp_r.off_screen, out_off_screen);
        end
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic test_directed();
    send_item(put_item("A", 8'hFF));
    send_item(put_item(8'h7E, 8'h00));
    send_item(put_item(GLYPH_CR, 8'h12));
    // backspace at the home position does nothing
    send_item(put_item(GLYPH_BS, 8'h34));
    send_item(put_item(8'hE4, 8'h5A));
    send_item(put_item(8'h80, 8'hA5));
    send_item(put_item(8'hA2, 8'h0F));
    send_item(put_item(8'h00, 8'hFF));
    send_item(put_item(8'hB3, 8'hFF));
    send_item(put_item(GLYPH_TAB, 8'h00));
    send_item(put_item(GLYPH_LF, 8'h00));
    // backspace at column 0 wraps to the last column of the row above
    send_item(put_item(GLYPH_BS, 8'h71));
    send_item(put_item(8'hFF, 8'hC3));
    send_item(set_item(6'd63, 7'd127));
    send_item(put_item("x", 8'h1E));
    send_item(put_item(GLYPH_LF, 8'h00));
    send_item(put_item(GLYPH_BS, 8'h2B));
    send_item(set_item(6'd49, 7'd79));
    send_item(put_item("z", 8'h80));
    send_item(set_item(6'd0, 7'd0));
    send_item(set_item(6'd50, 7'd80));
    send_item(set_item(6'd3, 7'd79));
    send_item(put_item(GLYPH_TAB, 8'h00));
    send_item(set_item(6'd50, 7'd5));
    send_item(put_item(GLYPH_BS, 8'hE7));
    drain();
  endtask

  task automatic test_random(input int s_pct, input int r_pct, input int count);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_item(random_item());
    drain();
  endtask

  // Hold the receiver off long enough that the block fills and stalls its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 60;
    repeat (40) send_item(random_item());
    drain();
    recv_idle_pct = 30;
    hold_req = 25;
    repeat (20) send_item(random_item());
    drain();
  endtask

  initial begin
    n_errors      = 0;
    cursor_col_q  = 0;
    cursor_row_q  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 0;
    hold_left     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(22, 60, 630);
    test_random(60, 22, 630);
    test_random(0, 0, 630);
    test_backpressure();
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ text_console_char_writer.f @@
rtl/core/tccw_pkg.sv
rtl/core/tccw_step.sv
rtl/core/text_console_char_writer.sv
rtl/core/tccw_checker.sv
tb/sv/tb.sv
